FILE: hw/rtl/ffba_pkg.sv
package ffba_pkg;

    // Pool geometry
    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 12;
    localparam int ADDR_W       = $clog2(POOL_BYTES);
    localparam int END_IDX      = POOL_BYTES - HEADER_BYTES;

    // Word field widths
    localparam int OP_W   = 2;
    localparam int REQ_W  = ADDR_W + 1;
    localparam int FREE_W = ADDR_W + 1;
    localparam int FREE_MAX = (1 << FREE_W) - 1;

    // Internal arithmetic widths
    localparam int END_W = ADDR_W + 2;
    localparam int GAP_W = ADDR_W + 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Header write selections
    localparam int WR_W = 3;
    localparam logic [WR_W-1:0] WR_NONE   = 3'd0;
    localparam logic [WR_W-1:0] WR_INIT0  = 3'd1;
    localparam logic [WR_W-1:0] WR_INIT1  = 3'd2;
    localparam logic [WR_W-1:0] WR_ALLOC1 = 3'd3;
    localparam logic [WR_W-1:0] WR_ALLOC2 = 3'd4;
    localparam logic [WR_W-1:0] WR_FREE   = 3'd5;

    typedef struct packed {
        logic            load;
        logic            eval;
        logic            step;
        logic            rd_next;
        logic            grant;
        logic            out_load;
        logic [WR_W-1:0] wr_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            fits;
        logic            walk_last;
    } dp_sts_t;

endpackage

FILE: hw/rtl/ffba_cmd_if.sv
interface ffba_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ffba_pkg::OP_W-1:0]    operation;
    logic [ffba_pkg::REQ_W-1:0]   request_bytes;
    logic [ffba_pkg::ADDR_W-1:0]  freed_offset;

    modport source (output valid, output operation, output request_bytes,
                    output freed_offset, input ready);
    modport sink   (input valid, input operation, input request_bytes,
                    input freed_offset, output ready);
endinterface

FILE: hw/rtl/ffba_rsp_if.sv
interface ffba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [ffba_pkg::ADDR_W-1:0]  granted_offset;
    logic [ffba_pkg::FREE_W-1:0]  free_bytes;

    modport source (output valid, output status, output granted_offset,
                    output free_bytes, input ready);
    modport sink   (input valid, input status, input granted_offset,
                    input free_bytes, output ready);
endinterface

FILE: hw/rtl/first_fit_block_allocator_top.sv
// Flow: a query or an allocate walks the headers from the anchor, each visit an evaluate state
// and then a check state; a successful allocate then writes the new header and its neighbours'
// links; a free evaluates its own header and relinks its neighbours; code 3 goes straight to the
// response. One word at a time: a new word is taken only once the sequencer is back in idle.
// Reset: asynchronous and active low; afterwards the sequencer writes the anchor and suffix
// headers, during which cmd.ready stays low. All other headers are undefined until written.
module first_fit_block_allocator_top (
    input  logic             clk,
    input  logic             rst_n,
    ffba_cmd_if.sink         cmd,
    ffba_rsp_if.source       rsp
);
    import ffba_pkg::*;

    // Command and status between the sequencer and the datapath.
    ctrl_cmd_t ctrl_cmd;
    dp_sts_t   dp_sts;

    // The sequencer owns the handshakes: a word is taken only when the engine is idle,
    // and a finished result waits in the output register until the sink takes it while
    // the next word is already accepted and walked.
    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (dp_sts),
        .cmd       (ctrl_cmd)
    );

    // The datapath holds the three header field stores (size, forward jump and backward
    // jump, one entry per byte offset), the walk registers and the result register.
    ffba_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctrl_cmd),
        .sts            (dp_sts),
        .operation      (cmd.operation),
        .request_bytes  (cmd.request_bytes),
        .freed_offset   (cmd.freed_offset),
        .status         (rsp.status),
        .granted_offset (rsp.granted_offset),
        .free_bytes     (rsp.free_bytes)
    );

endmodule

FILE: hw/rtl/ffba_ram.sv
module ffba_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/ffba_datapath.sv
module ffba_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ffba_pkg::ctrl_cmd_t          cmd,
    output ffba_pkg::dp_sts_t            sts,
    input  logic [ffba_pkg::OP_W-1:0]    operation,
    input  logic [ffba_pkg::REQ_W-1:0]   request_bytes,
    input  logic [ffba_pkg::ADDR_W-1:0]  freed_offset,
    output logic                         status,
    output logic [ffba_pkg::ADDR_W-1:0]  granted_offset,
    output logic [ffba_pkg::FREE_W-1:0]  free_bytes
);
    import ffba_pkg::*;

    // Word and walk registers
    logic [OP_W-1:0]   op_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [REQ_W:0]    req12_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] nxt_reg;
    logic [ADDR_W-1:0] pv_reg;
    logic [END_W-1:0]  end_reg;
    logic [ADDR_W-1:0] visits_reg;
    logic [FREE_W-1:0] sum_reg;
    logic              hit_reg;
    logic [ADDR_W-1:0] gnt_reg;

    logic              status_reg;
    logic [ADDR_W-1:0] granted_reg;
    logic [FREE_W-1:0] free_reg;

    // Header field stores
    logic [ADDR_W-1:0] size_rd, next_rd, prev_rd;
    logic [ADDR_W-1:0] raddr;
    logic              size_we, next_we, prev_we;
    logic [ADDR_W-1:0] size_wa, next_wa, prev_wa;
    logic [ADDR_W-1:0] size_wd, next_wd, prev_wd;

    // Arithmetic
    logic [ADDR_W-1:0] nb;
    logic [GAP_W-1:0]  diff;
    logic              gap_neg;
    logic [ADDR_W-1:0] gap_pos;
    logic [FREE_W:0]   sum_ext;
    logic [FREE_W-1:0] sum_next;
    logic [ADDR_W-1:0] jump;
    logic [ADDR_W-1:0] fwd_nb;
    logic [ADDR_W-1:0] back_nb;

    assign raddr = cmd.rd_next ? nxt_reg : idx_reg;
    assign nb    = end_reg[ADDR_W-1:0];

    // Gap between the end of the current block and the next header.
    assign diff    = GAP_W'(nxt_reg) - GAP_W'(end_reg);
    assign gap_neg = diff[GAP_W-1];
    assign gap_pos = gap_neg ? '0 : diff[ADDR_W-1:0];
    assign sum_ext = (FREE_W+1)'(sum_reg) + (FREE_W+1)'(gap_pos);
    assign sum_next = sum_ext[FREE_W] ? FREE_W'(FREE_MAX) : sum_ext[FREE_W-1:0];

    assign jump    = nxt_reg - pv_reg;
    assign fwd_nb  = nxt_reg - nb;
    assign back_nb = nb - idx_reg;

    assign sts.op        = op_reg;
    assign sts.fits      = !gap_neg && (diff >= GAP_W'(req12_reg));
    assign sts.walk_last = (nxt_reg >= ADDR_W'(END_IDX)) ||
                           (visits_reg == ADDR_W'(POOL_BYTES - 1));

    always_comb
    begin
        size_we = 1'b0; size_wa = '0; size_wd = '0;
        next_we = 1'b0; next_wa = '0; next_wd = '0;
        prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
        case (cmd.wr_sel)
            WR_INIT0:
            begin
                size_we = 1'b1;
                next_we = 1'b1; next_wd = ADDR_W'(END_IDX);
                prev_we = 1'b1;
            end
            WR_INIT1:
            begin
                size_we = 1'b1; size_wa = ADDR_W'(END_IDX);
                next_we = 1'b1; next_wa = ADDR_W'(END_IDX);
                prev_we = 1'b1; prev_wa = ADDR_W'(END_IDX); prev_wd = ADDR_W'(END_IDX);
            end
            WR_ALLOC1:
            begin
                size_we = 1'b1; size_wa = nb; size_wd = req_reg[ADDR_W-1:0];
                next_we = 1'b1; next_wa = nb; next_wd = fwd_nb;
                prev_we = 1'b1; prev_wa = nb; prev_wd = back_nb;
            end
            WR_ALLOC2:
            begin
                next_we = 1'b1; next_wa = idx_reg; next_wd = back_nb;
                prev_we = 1'b1; prev_wa = nxt_reg; prev_wd = fwd_nb;
            end
            WR_FREE:
            begin
                next_we = 1'b1; next_wa = pv_reg;  next_wd = jump;
                prev_we = 1'b1; prev_wa = nxt_reg; prev_wd = jump;
            end
            default:
            begin
                size_we = 1'b0;
            end
        endcase
    end

    ffba_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_BYTES)) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (size_wa),
        .wdata (size_wd),
        .raddr (raddr),
        .rdata (size_rd)
    );

    ffba_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_BYTES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_wa),
        .wdata (next_wd),
        .raddr (raddr),
        .rdata (next_rd)
    );

    ffba_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_BYTES)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_wa),
        .wdata (prev_wd),
        .raddr (raddr),
        .rdata (prev_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            req_reg    <= request_bytes;
            req12_reg  <= (REQ_W+1)'(request_bytes) + (REQ_W+1)'(HEADER_BYTES);
            idx_reg    <= (operation == OP_FREE) ? freed_offset - ADDR_W'(HEADER_BYTES)
                                                 : '0;
            visits_reg <= '0;
            sum_reg    <= '0;
            hit_reg    <= 1'b0;
        end
        if (cmd.eval)
        begin
            nxt_reg <= idx_reg + next_rd;
            pv_reg  <= idx_reg - prev_rd;
            end_reg <= END_W'(idx_reg) + END_W'(HEADER_BYTES) + END_W'(size_rd);
        end
        if (cmd.step)
        begin
            idx_reg    <= nxt_reg;
            visits_reg <= visits_reg + 1'b1;
            sum_reg    <= sum_next;
        end
        if (cmd.grant)
        begin
            hit_reg <= 1'b1;
            gnt_reg <= nb + ADDR_W'(HEADER_BYTES);
        end
        if (cmd.out_load)
        begin
            status_reg  <= (op_reg == OP_ALLOC) && !hit_reg;
            granted_reg <= hit_reg ? gnt_reg : '0;
            // The final step of the walk has already added the last block's gap.
            free_reg    <= (op_reg == OP_QUERY) ? sum_reg : '0;
        end
    end

    assign status         = status_reg;
    assign granted_offset = granted_reg;
    assign free_bytes     = free_reg;

    a_new_block_below_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_sel == WR_ALLOC1 |-> (nb < nxt_reg) && (nb > idx_reg))
        else $error("new block does not sit between its neighbours");

    a_load_clears_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (visits_reg == '0) && !hit_reg && (sum_reg == '0))
        else $error("walk state not cleared on a new word");

endmodule

FILE: hw/rtl/ffba_ctrl.sv
module ffba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ffba_pkg::dp_sts_t   sts,
    output ffba_pkg::ctrl_cmd_t cmd
);
    import ffba_pkg::*;

    localparam logic [3:0] S_INIT0    = 4'd0;
    localparam logic [3:0] S_INIT1    = 4'd1;
    localparam logic [3:0] S_IDLE     = 4'd2;
    localparam logic [3:0] S_LAUNCH   = 4'd3;
    localparam logic [3:0] S_WALK_EV  = 4'd4;
    localparam logic [3:0] S_WALK_CK  = 4'd5;
    localparam logic [3:0] S_ALLOC_W1 = 4'd6;
    localparam logic [3:0] S_ALLOC_W2 = 4'd7;
    localparam logic [3:0] S_FREE_EV  = 4'd8;
    localparam logic [3:0] S_FREE_WR  = 4'd9;
    localparam logic [3:0] S_RESP     = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_sel = WR_NONE;
        case (state_reg)
            S_INIT0:
            begin
                cmd.wr_sel = WR_INIT0;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                cmd.wr_sel = WR_INIT1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                if (sts.op == OP_FREE)
                begin
                    state_next = S_FREE_EV;
                end
                else if (sts.op == OP_ALLOC || sts.op == OP_QUERY)
                begin
                    state_next = S_WALK_EV;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_WALK_EV:
            begin
                cmd.eval   = 1'b1;
                state_next = S_WALK_CK;
            end
            S_WALK_CK:
            begin
                if (sts.op == OP_ALLOC && sts.fits)
                begin
                    state_next = S_ALLOC_W1;
                end
                else
                begin
                    cmd.step    = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = sts.walk_last ? S_RESP : S_WALK_EV;
                end
            end
            S_ALLOC_W1:
            begin
                cmd.wr_sel = WR_ALLOC1;
                cmd.grant  = 1'b1;
                state_next = S_ALLOC_W2;
            end
            S_ALLOC_W2:
            begin
                cmd.wr_sel = WR_ALLOC2;
                state_next = S_RESP;
            end
            S_FREE_EV:
            begin
                cmd.eval   = 1'b1;
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                cmd.wr_sel = WR_FREE;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_fit_allocates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_CK && sts.op == OP_ALLOC && sts.fits)
            |=> state_reg == S_ALLOC_W1 ##1 state_reg == S_ALLOC_W2)
        else $error("fitting gap did not lead to an allocation");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !out_valid_reg || $past(out_valid_reg))
        else $error("result raised straight after accepting a word");

endmodule
